/* rtl/dns_response_a_record_parser_defines.svh */
// Assertion macros for the DNS response A-record parser checker.
// Depends on nothing; include by bare file name.
`ifndef DNS_RESPONSE_A_RECORD_PARSER_DEFINES_SVH
`define DNS_RESPONSE_A_RECORD_PARSER_DEFINES_SVH

// check a property outside reset
`define DNSARP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property at every edge, reset included
`define DNSARP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/dnsarp_pkg.sv */
// Types and constants shared by the DNS response A-record parser.
// Depends on nothing.
package dnsarp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        status;
        logic [31:0] ip_addr;
    } t_out_item;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       is_zero;
        logic       is_ptr;
    } t_cls_item;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_QNAME  = 3'd1,
        PH_QFIXED = 3'd2,
        PH_ANAME  = 3'd3,
        PH_AFIXED = 3'd4,
        PH_RDATA  = 3'd5
    } t_phase;

    localparam logic [15:0] RESP_MASK    = 16'h8000;
    localparam logic [15:0] RCODE_MASK   = 16'h000F;
    localparam logic [7:0]  PTR_MASK     = 8'hC0;
    localparam logic [15:0] HEADER_BYTES = 16'd12;
    localparam logic [15:0] QFIXED_BYTES = 16'd4;
    localparam logic [15:0] AFIXED_BYTES = 16'd10;
    localparam logic [15:0] TYPE_A       = 16'd1;
    localparam logic [15:0] ADDR_BYTES   = 16'd4;

endpackage

/* rtl/dnsarp_fifo.sv */
// Small generic first-in first-out queue of registers.
// Depends on nothing.
module dnsarp_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          wr, rd;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) r_wr_ptr <= bump(r_wr_ptr);
            if (rd) r_rd_ptr <= bump(r_rd_ptr);
            if (wr && !rd) r_count <= r_count + 1'b1;
            else if (rd && !wr) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wr_ptr] <= i_data;
    end

endmodule

/* rtl/dnsarp_front.sv */
// Front end: accepts message bytes, marks name terminators and pointers, queues them.
// Depends on dnsarp_pkg and dnsarp_fifo.
module dnsarp_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  dnsarp_pkg::t_in_item  i_item,
    output logic                  o_full,
    input  logic                  i_take,
    output dnsarp_pkg::t_cls_item o_item,
    output logic                  o_valid
);
    import dnsarp_pkg::*;

    t_cls_item cls;
    logic      empty;

    always_comb begin
        cls.data_byte = i_item.data_byte;
        cls.last_byte = i_item.last_byte;
        cls.is_zero   = (i_item.data_byte == 8'd0);
        cls.is_ptr    = ((i_item.data_byte & PTR_MASK) == PTR_MASK);
    end

    dnsarp_fifo #(
        .W     ($bits(t_cls_item)),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cls),
        .o_full  (o_full),
        .i_pop   (i_take),
        .o_data  (o_item),
        .o_empty (empty)
    );

    assign o_valid = !empty;

endmodule

/* rtl/dnsarp_back.sv */
// Back end: walks header, questions and answers one byte per cycle while the result queue has room, emits the result.
// Depends on dnsarp_pkg.
module dnsarp_back #(
    parameter int MAX_MESSAGE_BYTES = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  dnsarp_pkg::t_cls_item i_item,
    output logic                  o_take,
    output logic                  o_push,
    output dnsarp_pkg::t_out_item o_res,
    input  logic                  i_full
);
    import dnsarp_pkg::*;

    localparam logic [15:0] MAX_BYTES = 16'(MAX_MESSAGE_BYTES);

    t_phase      r_phase, n_phase;
    logic [15:0] r_byte_count, n_byte_count;
    logic [15:0] r_header_flags, n_header_flags;
    logic [15:0] r_questions_left, n_questions_left;
    logic [15:0] r_answers_left, n_answers_left;
    logic [15:0] r_record_type, n_record_type;
    logic [31:0] r_addr_accum, n_addr_accum;
    logic        r_message_done, n_message_done;
    logic [15:0] r_part_pos, n_part_pos;
    logic [15:0] r_rd_len, n_rd_len;
    logic [7:0]  r_label_left, n_label_left;
    logic        r_ptr_pending, n_ptr_pending;

    logic emit, fail, do_clear, name_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_HEADER;
            r_byte_count     <= '0;
            r_header_flags   <= '0;
            r_questions_left <= '0;
            r_answers_left   <= '0;
            r_record_type    <= '0;
            r_addr_accum     <= '0;
            r_message_done   <= 1'b0;
            r_part_pos       <= '0;
            r_rd_len         <= '0;
            r_label_left     <= '0;
            r_ptr_pending    <= 1'b0;
        end else begin
            r_phase          <= n_phase;
            r_byte_count     <= n_byte_count;
            r_header_flags   <= n_header_flags;
            r_questions_left <= n_questions_left;
            r_answers_left   <= n_answers_left;
            r_record_type    <= n_record_type;
            r_addr_accum     <= n_addr_accum;
            r_message_done   <= n_message_done;
            r_part_pos       <= n_part_pos;
            r_rd_len         <= n_rd_len;
            r_label_left     <= n_label_left;
            r_ptr_pending    <= n_ptr_pending;
        end
    end

    always_comb begin
        n_phase          = r_phase;
        n_byte_count     = r_byte_count;
        n_header_flags   = r_header_flags;
        n_questions_left = r_questions_left;
        n_answers_left   = r_answers_left;
        n_record_type    = r_record_type;
        n_addr_accum     = r_addr_accum;
        n_message_done   = r_message_done;
        n_part_pos       = r_part_pos;
        n_rd_len         = r_rd_len;
        n_label_left     = r_label_left;
        n_ptr_pending    = r_ptr_pending;
        emit             = 1'b0;
        fail             = 1'b0;
        do_clear         = 1'b0;
        name_done        = 1'b0;
        o_take           = i_valid && !i_full;
        o_push           = 1'b0;
        o_res.status     = 1'b1;
        o_res.ip_addr    = '0;

        if (o_take) begin
            if (r_message_done) begin
                do_clear = i_item.last_byte;
            end else begin
                if (r_byte_count >= MAX_BYTES) begin
                    emit = 1'b1;
                    fail = 1'b1;
                end else begin
                    n_byte_count = r_byte_count + 16'd1;
                    case (r_phase)
                        PH_HEADER: begin
                            if (r_part_pos inside {16'd2, 16'd3})
                                n_header_flags = {r_header_flags[7:0], i_item.data_byte};
                            else if (r_part_pos inside {16'd4, 16'd5})
                                n_questions_left = {r_questions_left[7:0], i_item.data_byte};
                            else if (r_part_pos inside {16'd6, 16'd7})
                                n_answers_left = {r_answers_left[7:0], i_item.data_byte};
                            n_part_pos = r_part_pos + 16'd1;
                            if (n_part_pos == HEADER_BYTES) begin
                                n_part_pos = '0;
                                if ((n_header_flags & RESP_MASK) == '0 ||
                                    (n_header_flags & RCODE_MASK) != '0 ||
                                    n_answers_left == '0) begin
                                    emit = 1'b1;
                                    fail = 1'b1;
                                end else begin
                                    n_phase = (n_questions_left == '0) ? PH_ANAME : PH_QNAME;
                                end
                            end
                        end
                        PH_QNAME, PH_ANAME: begin
                            if (r_ptr_pending) begin
                                n_ptr_pending = 1'b0;
                                name_done     = 1'b1;
                            end else if (r_label_left != '0) begin
                                n_label_left = r_label_left - 8'd1;
                            end else if (i_item.is_zero) begin
                                name_done = 1'b1;
                            end else if (i_item.is_ptr) begin
                                n_ptr_pending = 1'b1;
                            end else begin
                                n_label_left = i_item.data_byte;
                            end
                            if (name_done) begin
                                n_part_pos = '0;
                                if (r_phase == PH_QNAME) begin
                                    n_phase = PH_QFIXED;
                                end else begin
                                    n_phase       = PH_AFIXED;
                                    n_record_type = '0;
                                    n_rd_len      = '0;
                                end
                            end
                        end
                        PH_QFIXED: begin
                            n_part_pos = r_part_pos + 16'd1;
                            if (n_part_pos == QFIXED_BYTES) begin
                                n_part_pos       = '0;
                                n_questions_left = r_questions_left - 16'd1;
                                n_phase = (n_questions_left == '0) ? PH_ANAME : PH_QNAME;
                            end
                        end
                        PH_AFIXED: begin
                            if (r_part_pos inside {16'd0, 16'd1})
                                n_record_type = {r_record_type[7:0], i_item.data_byte};
                            else if (r_part_pos inside {16'd8, 16'd9})
                                n_rd_len = {r_rd_len[7:0], i_item.data_byte};
                            n_part_pos = r_part_pos + 16'd1;
                            if (n_part_pos == AFIXED_BYTES) begin
                                if (n_record_type == TYPE_A && n_rd_len == ADDR_BYTES) begin
                                    n_phase      = PH_RDATA;
                                    n_part_pos   = '0;
                                    n_addr_accum = '0;
                                end else if (n_rd_len == '0) begin
                                    n_answers_left = r_answers_left - 16'd1;
                                    if (n_answers_left == '0) begin
                                        emit = 1'b1;
                                        fail = 1'b1;
                                    end else begin
                                        n_phase       = PH_ANAME;
                                        n_label_left  = '0;
                                        n_ptr_pending = 1'b0;
                                    end
                                end else begin
                                    n_phase    = PH_RDATA;
                                    n_part_pos = n_rd_len;
                                end
                            end
                        end
                        PH_RDATA: begin
                            if (r_record_type == TYPE_A && r_rd_len == ADDR_BYTES) begin
                                n_addr_accum = {r_addr_accum[23:0], i_item.data_byte};
                                n_part_pos   = r_part_pos + 16'd1;
                                if (n_part_pos >= ADDR_BYTES) emit = 1'b1;
                            end else begin
                                n_part_pos = r_part_pos - 16'd1;
                                if (n_part_pos == '0) begin
                                    n_answers_left = r_answers_left - 16'd1;
                                    if (n_answers_left == '0) begin
                                        emit = 1'b1;
                                        fail = 1'b1;
                                    end else begin
                                        n_phase       = PH_ANAME;
                                        n_label_left  = '0;
                                        n_ptr_pending = 1'b0;
                                    end
                                end
                            end
                        end
                        default: begin
                            n_phase = PH_HEADER;
                        end
                    endcase
                end

                if (!emit && i_item.last_byte) begin
                    emit = 1'b1;
                    fail = 1'b1;
                end

                if (emit) begin
                    o_push        = 1'b1;
                    o_res.status  = fail;
                    o_res.ip_addr = fail ? 32'd0 : n_addr_accum;
                    if (i_item.last_byte) do_clear = 1'b1;
                    else n_message_done = 1'b1;
                end
            end
        end

        if (do_clear) begin
            n_phase          = PH_HEADER;
            n_byte_count     = '0;
            n_header_flags   = '0;
            n_questions_left = '0;
            n_answers_left   = '0;
            n_record_type    = '0;
            n_addr_accum     = '0;
            n_message_done   = 1'b0;
            n_part_pos       = '0;
            n_rd_len         = '0;
            n_label_left     = '0;
            n_ptr_pending    = 1'b0;
        end
    end

endmodule

/* rtl/dns_response_a_record_parser.sv */
// DNS response A-record parser: takes a response one byte per transaction, flagged on its
// last byte, and gives one result per message: status 0 with the IPv4 address of the first
// type-1 answer whose rdata is 4 bytes, or status 1 with a zero address when the header
// is rejected, no such answer exists, the message ends early or runs past
// MAX_MESSAGE_BYTES. Bytes after the result up to the last byte are dropped. One byte is
// taken every cycle while the result queue has room. On its way out, a deciding byte is
// first stored in the front byte queue, and the parser writes the result queue as it
// takes that byte. Full rises only when the result queue is left unread.
// Depends on dnsarp_pkg, dnsarp_front, dnsarp_back and dnsarp_fifo.
module dns_response_a_record_parser #(
    parameter int MAX_MESSAGE_BYTES = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    input  dnsarp_pkg::t_in_item  i_item,
    output logic                  full,
    output logic                  empty,
    input  logic                  pop,
    output dnsarp_pkg::t_out_item o_result
);
    import dnsarp_pkg::*;

    t_cls_item cls_item;
    t_out_item res;
    logic      cls_valid, take, res_push, res_full;

    dnsarp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .o_full  (full),
        .i_take  (take),
        .o_item  (cls_item),
        .o_valid (cls_valid)
    );

    dnsarp_back #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cls_valid),
        .i_item  (cls_item),
        .o_take  (take),
        .o_push  (res_push),
        .o_res   (res),
        .i_full  (res_full)
    );

    dnsarp_fifo #(
        .W     ($bits(t_out_item)),
        .DEPTH (2)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule

/* rtl/dnsarp_checker.sv */
// Port-level checks for the DNS response A-record parser, bound to its top level.
// Depends on dnsarp_pkg and dns_response_a_record_parser_defines.svh.
`include "dns_response_a_record_parser_defines.svh"

module dnsarp_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  full,
    input logic                  empty,
    input logic                  pop,
    input dnsarp_pkg::t_out_item o_result
);
    import dnsarp_pkg::*;

    `DNSARP_ASSERT(fail_zero_addr, i_clk, i_rst_n, (!empty && o_result.status) |-> (o_result.ip_addr == 32'd0), "failure result carries a nonzero address")
    `DNSARP_ASSERT(result_held, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_result)), "waiting result lost or changed")
    `DNSARP_ASSERT_ALWAYS(reset_empty, i_clk, !i_rst_n |=> empty, "result queue not empty after reset")
    `DNSARP_ASSERT_ALWAYS(reset_not_full, i_clk, !i_rst_n |=> !full, "input reports full after reset")

endmodule

bind dns_response_a_record_parser dnsarp_checker u_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

/* tb/sv/tb_dns_response_a_record_parser.sv */
// Testbench for dns_response_a_record_parser: directed and random DNS responses sent byte by
// byte under bursty input and stalling output, each result checked against a local parse.
// Depends on dnsarp_pkg and the dns_response_a_record_parser RTL.
`timescale 1ns / 100ps

module tb_dns_response_a_record_parser;
    import dnsarp_pkg::*;

    localparam int          MAX_MSG_BYTES = 512;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          TAIL_CYCLES   = 20;
    localparam int          HOLD_CYCLES   = 500;
    localparam int          HOLD_MSGS     = 16;
    localparam int          RANDOM_BYTES  = 40;
    localparam int          RANDOM_MSGS   = 3;
    localparam int          CUT_STEP      = 12;
    localparam int          RDLEN_HI_AT   = 22;
    localparam logic [15:0] FLAGS_OK      = 16'h8180;

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    t_in_item  i_item  = '0;
    logic      full;
    logic      empty;
    logic      pop     = 1'b0;
    t_out_item o_result;

    dns_response_a_record_parser #(
        .MAX_MESSAGE_BYTES(MAX_MSG_BYTES)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .i_item  (i_item),
        .full    (full),
        .empty   (empty),
        .pop     (pop),
        .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // parse state of the response in flight
    t_phase      ph;
    logic [15:0] nbytes;
    logic [15:0] hflags;
    logic [15:0] qleft;
    logic [15:0] aleft;
    logic [15:0] rtype;
    logic [15:0] rdlen;
    logic [15:0] ppos;
    logic [31:0] acc;
    logic [7:0]  lleft;
    logic        ptrp;
    logic        msg_done;

    t_out_item   lookup_results_q[$];
    t_out_item   want_result;
    logic [7:0]  msg_buf[$];
    int          err_count  = 0;
    int          live_bytes = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    bit          tx_bursty  = 1'b1;
    bit          hold_tog   = 1'b0;

    function automatic void parser_clear();
        ph       = PH_HEADER;
        nbytes   = '0;
        hflags   = '0;
        qleft    = '0;
        aleft    = '0;
        rtype    = '0;
        rdlen    = '0;
        ppos     = '0;
        acc      = '0;
        lleft    = '0;
        ptrp     = 1'b0;
        msg_done = 1'b0;
    endfunction

    function automatic bit name_step(input logic [7:0] b);
        if (ptrp) begin
            ptrp = 1'b0;
            return 1'b1;
        end
        if (lleft != 0) begin
            lleft = lleft - 1'b1;
            return 1'b0;
        end
        if (b == 8'h00)
            return 1'b1;
        if ((b & PTR_MASK) == PTR_MASK) begin
            ptrp = 1'b1;
            return 1'b0;
        end
        lleft = b;
        return 1'b0;
    endfunction

    function automatic bit answers_exhausted();
        aleft = aleft - 1'b1;
        if (aleft == 0)
            return 1'b1;
        ph    = PH_ANAME;
        lleft = '0;
        ptrp  = 1'b0;
        return 1'b0;
    endfunction

    function automatic void track_dns_byte(input logic [7:0] b, input logic last);
        bit        emit;
        bit        fail;
        t_out_item res;
        emit = 1'b0;
        fail = 1'b0;
        if (msg_done) begin
            if (last)
                parser_clear();
            return;
        end
        live_bytes++;
        if (nbytes >= MAX_MSG_BYTES) begin
            emit = 1'b1;
            fail = 1'b1;
        end else begin
            nbytes = nbytes + 1'b1;
            case (ph)
                PH_HEADER: begin
                    if (ppos == 2 || ppos == 3)
                        hflags = {hflags[7:0], b};
                    else if (ppos == 4 || ppos == 5)
                        qleft = {qleft[7:0], b};
                    else if (ppos == 6 || ppos == 7)
                        aleft = {aleft[7:0], b};
                    ppos = ppos + 1'b1;
                    if (ppos == HEADER_BYTES) begin
                        ppos = '0;
                        if ((hflags & RESP_MASK) == 0 || (hflags & RCODE_MASK) != 0 ||
                            aleft == 0) begin
                            emit = 1'b1;
                            fail = 1'b1;
                        end else begin
                            ph = (qleft == 0) ? PH_ANAME : PH_QNAME;
                        end
                    end
                end
                PH_QNAME: begin
                    if (name_step(b)) begin
                        ph   = PH_QFIXED;
                        ppos = '0;
                    end
                end
                PH_QFIXED: begin
                    ppos = ppos + 1'b1;
                    if (ppos == QFIXED_BYTES) begin
                        ppos  = '0;
                        qleft = qleft - 1'b1;
                        ph    = (qleft == 0) ? PH_ANAME : PH_QNAME;
                    end
                end
                PH_ANAME: begin
                    if (name_step(b)) begin
                        ph    = PH_AFIXED;
                        ppos  = '0;
                        rtype = '0;
                        rdlen = '0;
                    end
                end
                PH_AFIXED: begin
                    if (ppos == 0 || ppos == 1)
                        rtype = {rtype[7:0], b};
                    else if (ppos == 8 || ppos == 9)
                        rdlen = {rdlen[7:0], b};
                    ppos = ppos + 1'b1;
                    if (ppos == AFIXED_BYTES) begin
                        if (rtype == TYPE_A && rdlen == ADDR_BYTES) begin
                            ph   = PH_RDATA;
                            ppos = '0;
                            acc  = '0;
                        end else if (rdlen == 0) begin
                            if (answers_exhausted()) begin
                                emit = 1'b1;
                                fail = 1'b1;
                            end
                        end else begin
                            ph   = PH_RDATA;
                            ppos = rdlen;
                        end
                    end
                end
                default: begin
                    if (rtype == TYPE_A && rdlen == ADDR_BYTES) begin
                        acc  = {acc[23:0], b};
                        ppos = ppos + 1'b1;
                        if (ppos >= ADDR_BYTES)
                            emit = 1'b1;
                    end else begin
                        ppos = ppos - 1'b1;
                        if (ppos == 0) begin
                            if (answers_exhausted()) begin
                                emit = 1'b1;
                                fail = 1'b1;
                            end
                        end
                    end
                end
            endcase
        end
        if (!emit && last) begin
            emit = 1'b1;
            fail = 1'b1;
        end
        if (!emit)
            return;
        res.status  = fail;
        res.ip_addr = fail ? 32'h0 : acc;
        lookup_results_q.push_back(res);
        if (last)
            parser_clear();
        else
            msg_done = 1'b1;
    endfunction

    function automatic void put16(input logic [15:0] v);
        msg_buf.push_back(v[15:8]);
        msg_buf.push_back(v[7:0]);
    endfunction

    function automatic void put_header(input logic [15:0] flags, input logic [15:0] qd,
                                       input logic [15:0] an);
        put16(16'($urandom));
        put16(flags);
        put16(qd);
        put16(an);
        put16(16'($urandom));
        put16(16'($urandom));
    endfunction

    function automatic void put_name(input int labels, input bit ptr_end);
        int len;
        for (int i = 0; i < labels; i++) begin
            len = ($urandom_range(0, 39) == 0) ? $urandom_range(7, 191) : $urandom_range(1, 6);
            msg_buf.push_back(8'(len));
            repeat (len) msg_buf.push_back(8'($urandom));
        end
        if (ptr_end) begin
            msg_buf.push_back(PTR_MASK | 8'($urandom_range(0, 63)));
            msg_buf.push_back(8'($urandom));
        end else begin
            msg_buf.push_back(8'h00);
        end
    endfunction

    function automatic void put_question(input int labels, input bit ptr_end);
        put_name(labels, ptr_end);
        put16(16'($urandom));
        put16(16'($urandom));
    endfunction

    function automatic void put_answer(input logic [15:0] rt, input logic [15:0] rl,
                                       input logic [31:0] addr);
        put16(rt);
        put16(16'($urandom));
        put16(16'($urandom));
        put16(16'($urandom));
        put16(rl);
        if (rt == TYPE_A && rl == ADDR_BYTES) begin
            put16(addr[31:16]);
            put16(addr[15:0]);
        end else begin
            repeat (rl) msg_buf.push_back(8'($urandom));
        end
    endfunction

    function automatic void put_noise(input int lo, input int hi);
        repeat ($urandom_range(lo, hi)) msg_buf.push_back(8'($urandom));
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR @%0t: %s got %h want %h", $time, what, got, want);
        err_count++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        push   <= 1'b1;
        i_item <= {b, last};
        do @(posedge i_clk); while (full);
        track_dns_byte(b, last);
        if (tx_bursty) begin
            if (burst_left == 0) begin
                push <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                burst_left = $urandom_range(1, 24);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_msg();
        for (int k = 0; k < msg_buf.size(); k++)
            send_byte(msg_buf[k], k == msg_buf.size() - 1);
        msg_buf.delete();
    endtask

    task automatic test_header_checks();
        put_header(16'h0180, 16'd1, 16'd1);
        send_msg();
        put_header(16'h8183, 16'd0, 16'd1);
        send_msg();
        put_header(16'h800F, 16'd0, 16'd1);
        put_noise(1, 4);
        send_msg();
        put_header(FLAGS_OK, 16'd0, 16'd0);
        put_noise(2, 6);
        send_msg();
        put_header(16'hFFF0, 16'd0, 16'd1);
        put_name(0, 1'b0);
        put_answer(TYPE_A, ADDR_BYTES, 32'hFFFF_FFFF);
        send_msg();
    endtask

    task automatic test_single_byte();
        msg_buf.push_back(8'h00);
        send_msg();
        msg_buf.push_back(8'hFF);
        send_msg();
    endtask

    task automatic test_a_records();
        put_header(FLAGS_OK, 16'd0, 16'd1);
        put_name(0, 1'b0);
        put_answer(TYPE_A, ADDR_BYTES, 32'h0000_0000);
        send_msg();
        put_header(16'h8580, 16'd2, 16'd1);
        put_question(1, 1'b0);
        put_question(1, 1'b1);
        put_name(1, 1'b1);
        put_answer(TYPE_A, ADDR_BYTES, 32'h0A00_0001);
        put_noise(1, 1);
        send_msg();
        // longest plain label: the answer that follows sits inside it
        put_header(FLAGS_OK, 16'd0, 16'd1);
        msg_buf.push_back(8'hBF);
        msg_buf.push_back(8'h00);
        put_answer(TYPE_A, ADDR_BYTES, 32'hC0A8_0101);
        send_msg();
    endtask

    task automatic test_skipped_answers();
        put_header(FLAGS_OK, 16'd0, 16'd3);
        put_name(0, 1'b0);
        put_answer(16'd5, 16'd6, 32'h0);
        put_name(1, 1'b1);
        put_answer(TYPE_A, 16'd0, 32'h0);
        put_name(0, 1'b1);
        put_answer(TYPE_A, 16'd5, 32'h0);
        put_noise(3, 3);
        send_msg();
        put_header(FLAGS_OK, 16'd1, 16'd2);
        put_question(1, 1'b0);
        put_name(0, 1'b1);
        put_answer(16'h0101, ADDR_BYTES, 32'h0);
        put_name(0, 1'b1);
        put_answer(TYPE_A, ADDR_BYTES, 32'h8000_0001);
        send_msg();
        // rdata length with a nonzero high byte, message ends inside the rdata
        put_header(FLAGS_OK, 16'd0, 16'd1);
        put_name(0, 1'b1);
        put_answer(TYPE_A, ADDR_BYTES, 32'h0A0B_0C0D);
        msg_buf[RDLEN_HI_AT] = 8'h01;
        put_noise(2, 2);
        send_msg();
        put_header(FLAGS_OK, 16'd0, 16'd1);
        put_name(0, 1'b0);
        put_answer(16'h0000, 16'd0, 32'h0);
        send_msg();
    endtask

    task automatic test_early_end();
        logic [7:0] tmpl[$];
        put_header(FLAGS_OK, 16'd1, 16'd1);
        put_question(2, 1'b0);
        put_name(1, 1'b1);
        put_answer(TYPE_A, ADDR_BYTES, $urandom);
        tmpl = msg_buf;
        msg_buf.delete();
        for (int cut = $urandom_range(1, CUT_STEP); cut < tmpl.size(); cut += CUT_STEP) begin
            msg_buf = tmpl;
            while (msg_buf.size() > cut)
                void'(msg_buf.pop_back());
            send_msg();
        end
    endtask

    task automatic test_overlong();
        put_header(FLAGS_OK, 16'hFFFF, 16'd1);
        repeat (100) put_question(0, 1'b0);
        put_noise(3, 3);
        send_msg();
    endtask

    task automatic test_pressure();
        tx_bursty = 1'b0;
        hold_tog <= ~hold_tog;
        repeat (HOLD_MSGS) begin
            msg_buf.push_back(8'($urandom));
            send_msg();
        end
        tx_bursty = 1'b1;
    endtask

    task automatic test_random();
        int          kind;
        int          msgs;
        int          pick;
        logic [15:0] flags;
        logic [15:0] an;
        logic [15:0] rt;
        logic [15:0] rl;
        msgs       = 0;
        live_bytes = 0;
        while (live_bytes < RANDOM_BYTES || msgs < RANDOM_MSGS) begin
            kind = $urandom_range(0, 19);
            if (kind % 7 == 6)
                tx_bursty = ~tx_bursty;
            if (kind < 3) begin
                put_noise(1, 40);
            end else if (kind < 5) begin
                flags = 16'($urandom);
                an    = 16'($urandom_range(1, 3));
                pick  = $urandom_range(0, 2);
                if (pick == 0)
                    flags[15] = 1'b0;
                else if (pick == 1)
                    flags[3:0] = 4'($urandom_range(1, 15));
                else
                    an = '0;
                put_header(flags, 16'($urandom_range(0, 2)), an);
                put_noise(0, 20);
            end else begin
                flags       = 16'($urandom);
                flags[15]   = 1'b1;
                flags[3:0]  = '0;
                an          = 16'($urandom_range(1, 3));
                put_header(flags, 16'($urandom_range(0, 2)), an);
                repeat ({msg_buf[4], msg_buf[5]})
                    put_question($urandom_range(0, 3), 1'($urandom_range(0, 1)));
                repeat (an) begin
                    put_name($urandom_range(0, 3), 1'($urandom_range(0, 1)));
                    pick = $urandom_range(0, 9);
                    if (pick < 5) begin
                        rt = TYPE_A;
                        rl = ADDR_BYTES;
                    end else if (pick < 7) begin
                        rt = TYPE_A;
                        rl = 16'($urandom_range(0, 8));
                    end else begin
                        rt = 16'($urandom);
                        rl = 16'($urandom_range(0, 8));
                    end
                    put_answer(rt, rl, $urandom);
                end
                if (kind < 7) begin
                    pick = $urandom_range(1, msg_buf.size());
                    while (msg_buf.size() > pick)
                        void'(msg_buf.pop_back());
                end else begin
                    put_noise(0, 4);
                end
            end
            send_msg();
            msgs++;
        end
        tx_bursty = 1'b1;
    endtask

    initial begin : rx_side
        int run_left;
        bit run_on;
        bit seen_tog;
        int hold_left;
        run_left  = 0;
        run_on    = 1'b1;
        seen_tog  = 1'b0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_tog != seen_tog) begin
                seen_tog  = hold_tog;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    run_on   = ($urandom_range(0, 2) != 0);
                    run_left = run_on ? $urandom_range(1, 40) : $urandom_range(1, 10);
                end
                run_left--;
                pop <= run_on;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (lookup_results_q.size() == 0) begin
                report_mismatch("result with none pending", o_result.ip_addr, 32'h0);
            end else begin
                want_result = lookup_results_q.pop_front();
                if (o_result.status !== want_result.status)
                    report_mismatch("status", 32'(o_result.status),
                                    32'(want_result.status));
                if (o_result.ip_addr !== want_result.ip_addr)
                    report_mismatch("ip_addr", o_result.ip_addr, want_result.ip_addr);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("dns_response_a_record_parser: mismatch");
            $finish;
        end
    end

    initial begin
        parser_clear();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_header_checks();
        test_single_byte();
        test_a_records();
        test_skipped_answers();
        test_early_end();
        test_overlong();
        test_pressure();
        test_random();
        push <= 1'b0;
        while (lookup_results_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("dns_response_a_record_parser: match");
        end else begin
            $display("dns_response_a_record_parser: mismatch");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/dnsarp_pkg.sv
rtl/dnsarp_fifo.sv
rtl/dnsarp_front.sv
rtl/dnsarp_back.sv
rtl/dns_response_a_record_parser.sv
rtl/dnsarp_checker.sv
tb/sv/tb_dns_response_a_record_parser.sv
